FILE: design/ngns_pkg.sv
package ngns_pkg;

   localparam int COORD_IN_W    = 32;
   localparam int ENTRY_INDEX_W = 10;
   localparam int NODE_INDEX_W  = 10;
   localparam int COUNT_W       = 11;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd2;

   typedef struct packed {
      logic load_query;
      logic write_entry;
      logic step_sel;
      logic bound_upd;
      logic step_upd;
      logic push;
   } dp_cmd_type;

   typedef struct packed {
      logic bound_hit;
      logic step_done;
   } dp_status_type;

endpackage

FILE: design/ngns_ctrl.sv
module ngns_ctrl
   import ngns_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_BND_RD   = 3'd1;
   localparam logic [2:0] ST_BND_CMP  = 3'd2;
   localparam logic [2:0] ST_STEP_RD  = 3'd3;
   localparam logic [2:0] ST_STEP_CMP = 3'd4;
   localparam logic [2:0] ST_HOLD     = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_QUERY) begin
                  dp_cmd.load_query = 1'b1;
                  state_in          = ST_BND_RD;
               end else begin
                  dp_cmd.write_entry = 1'b1;
               end
            end
         end
         ST_BND_RD: begin
            state_in = ST_BND_CMP;
         end
         ST_BND_CMP: begin
            dp_cmd.bound_upd = 1'b1;
            state_in         = dp_status.bound_hit ? ST_HOLD : ST_STEP_RD;
         end
         ST_STEP_RD: begin
            dp_cmd.step_sel = 1'b1;
            state_in        = ST_STEP_CMP;
         end
         ST_STEP_CMP: begin
            dp_cmd.step_sel = 1'b1;
            dp_cmd.step_upd = 1'b1;
            state_in        = dp_status.step_done ? ST_HOLD : ST_STEP_RD;
         end
         ST_HOLD: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.push = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (dp_cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/ngns_datapath.sv
module ngns_datapath
   import ngns_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int COORD_WIDTH = 32
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [COUNT_W-1:0]             csr_wr_data,
   input  logic [ENTRY_INDEX_W-1:0]       req_entry_index,
   input  logic signed [COORD_IN_W-1:0]   req_coordinate,
   output logic [NODE_INDEX_W-1:0]        rsp_node_index,
   input  dp_cmd_type                     dp_cmd,
   output dp_status_type                  dp_status
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [COORD_WIDTH-1:0] mem [TABLE_DEPTH];

   logic [COUNT_W-1:0]      node_count_ff;
   logic [COORD_WIDTH-1:0]  q_ff;
   logic [IDX_W-1:0]        lo_ff, lo_in;
   logic [IDX_W-1:0]        hi_ff, hi_in;
   logic [COORD_WIDTH-1:0]  rd_a_ff, rd_b_ff;
   logic [NODE_INDEX_W-1:0] node_index_ff;

   logic signed [COORD_WIDTH-1:0] coord_sized;
   logic [COORD_WIDTH-1:0]        key;
   logic [IDX_W-1:0]              last_idx;
   logic [IDX_W-1:0]              mid;
   logic [IDX_W-1:0]              mid_next;
   logic [IDX_W-1:0]              addr_a, addr_b;
   logic [IDX_W-1:0]              wr_addr;
   logic                          wr_in_range;
   logic                          q_below, q_above, at_or_above;
   logic [COORD_WIDTH:0]          q_twice, pair_sum;

   // offset binary keys compare as unsigned
   assign coord_sized = COORD_WIDTH'(req_coordinate);
   assign key         = {~coord_sized[COORD_WIDTH-1], coord_sized[COORD_WIDTH-2:0]};

   always_comb begin
      priority if (node_count_ff < 11'd2) begin
         last_idx = IDX_W'(1);
      end else if (32'(node_count_ff) > TABLE_DEPTH) begin
         last_idx = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_idx = IDX_W'(node_count_ff - 11'd1);
      end
   end

   assign mid      = lo_ff + IDX_W'((hi_ff - lo_ff) >> 1);
   assign mid_next = mid + IDX_W'(1);
   assign addr_a   = dp_cmd.step_sel ? mid      : lo_ff;
   assign addr_b   = dp_cmd.step_sel ? mid_next : hi_ff;

   assign wr_addr     = IDX_W'(req_entry_index);
   assign wr_in_range = (32'(req_entry_index) < TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (dp_cmd.write_entry && wr_in_range) begin
         mem[wr_addr] <= key;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // exact midpoint test: 2q >= a + b, one bit wider
   assign q_below     = (q_ff < rd_a_ff);
   assign q_above     = (q_ff > rd_b_ff);
   assign q_twice     = {q_ff, 1'b0};
   assign pair_sum    = {1'b0, rd_a_ff} + {1'b0, rd_b_ff};
   assign at_or_above = (q_twice >= pair_sum);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      priority if (dp_cmd.load_query) begin
         lo_in = '0;
         hi_in = last_idx;
      end else if (dp_cmd.bound_upd) begin
         // collapse the range onto the bound hit; the result is always lo
         if (q_below) begin
            hi_in = '0;
         end else if (q_above) begin
            lo_in = hi_ff;
         end
      end else if (dp_cmd.step_upd) begin
         if (at_or_above) begin
            lo_in = mid_next;
         end else begin
            hi_in = mid;
         end
      end else begin
         // hold the range
         lo_in = lo_ff;
         hi_in = hi_ff;
      end
   end

   assign dp_status.bound_hit = q_below || q_above;
   assign dp_status.step_done = (lo_in == hi_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_query) begin
         q_ff <= key;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (dp_cmd.push) begin
         node_index_ff <= NODE_INDEX_W'(lo_ff);
      end
   end

   assign rsp_node_index = node_index_ff;

endmodule

FILE: design/nearest_grid_node_search.sv
// Table write: no result word, and the block stays idle.
// Query: result word after the bounds compare and S bisection steps; the next word is taken
// once that word is pushed. S is the bisection steps, at most ceil(log2(n)) for n active nodes,
// and S = 0 for a query outside the first and last node.
// Each step is a two-port table read and a midpoint compare; a stalled result holds the next.
// Reset (synchronous, active high) clears control, sets node_count to 2, leaves the table as is.
module nearest_grid_node_search
   import ngns_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int COORD_WIDTH = 32
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [COUNT_W-1:0]           csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [ENTRY_INDEX_W-1:0]     req_entry_index,
   input  logic signed [COORD_IN_W-1:0] req_coordinate,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [NODE_INDEX_W-1:0]      rsp_node_index
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ngns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   ngns_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_entry_index (req_entry_index),
      .req_coordinate  (req_coordinate),
      .rsp_node_index  (rsp_node_index),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status)
   );

endmodule

FILE: design/ngns_checker.sv
module ngns_checker
   import ngns_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_cmd,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [NODE_INDEX_W-1:0] rsp_node_index
);

   // a stalled result word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_node_index))
      else $error("result word dropped or changed under stall");

   // a table write never occupies the block
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == CMD_WRITE |=> !req_stall)
      else $error("block busy after a table write");

   // a query keeps the block busy while it searches
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == CMD_QUERY |=> req_stall ##1 req_stall)
      else $error("block free too early after a query");

   // a new result word appears only at the end of a search
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word without a search in progress");

endmodule

bind nearest_grid_node_search ngns_checker u_ngns_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_node_index (rsp_node_index)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ngns_pkg::*;

   localparam int NODE_DEPTH     = 1024;
   localparam int SETTLE_CYCLES  = 30;
   localparam int QUIET_LIMIT    = 4000;
   localparam int TARGET_WORDS   = 1750;
   localparam int N_DIRECTED     = 21;
   localparam int N_SWEEP        = 7;
   localparam logic [31:0] COORD_MIN  = 32'h8000_0000;
   localparam logic [31:0] COORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] KEY_OFFSET = 32'h8000_0000;

   typedef struct packed {
      logic                     cmd;
      logic [ENTRY_INDEX_W-1:0] entry;
      logic [COORD_IN_W-1:0]    coord;
      logic                     typed;
      logic [NODE_INDEX_W-1:0]  node;
   } stim_row_type;

   // fixed answers only where the nearest node is plain to see
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{CMD_WRITE, 10'd0,    COORD_MIN,     1'b0, 10'd0},
      '{CMD_WRITE, 10'd1,    COORD_MAX,     1'b0, 10'd0},
      '{CMD_QUERY, 10'd0,    COORD_MIN,     1'b1, 10'd0},
      '{CMD_QUERY, 10'd0,    COORD_MAX,     1'b1, 10'd1},
      '{CMD_QUERY, 10'd0,    32'd0,         1'b1, 10'd1},
      '{CMD_QUERY, 10'd0,    32'hFFFF_FFFF, 1'b1, 10'd0},
      '{CMD_WRITE, 10'd0,    32'd0,         1'b0, 10'd0},
      '{CMD_WRITE, 10'd1,    32'd2,         1'b0, 10'd0},
      '{CMD_QUERY, 10'd0,    32'd1,         1'b1, 10'd1},
      '{CMD_QUERY, 10'd0,    32'd0,         1'b1, 10'd0},
      '{CMD_QUERY, 10'd0,    32'd2,         1'b1, 10'd1},
      '{CMD_QUERY, 10'd0,    32'hFFFF_FFFB, 1'b1, 10'd0},
      '{CMD_QUERY, 10'd0,    COORD_MAX,     1'b1, 10'd1},
      '{CMD_QUERY, 10'd0,    COORD_MIN,     1'b1, 10'd0},
      '{CMD_WRITE, 10'd1023, COORD_MAX,     1'b0, 10'd0},
      '{CMD_WRITE, 10'd1,    32'd0,         1'b0, 10'd0},
      '{CMD_QUERY, 10'd0,    32'd0,         1'b1, 10'd1},
      '{CMD_QUERY, 10'd1023, 32'd0,         1'b1, 10'd1},
      '{CMD_WRITE, 10'd1,    32'hFFFF_0000, 1'b0, 10'd0},
      '{CMD_QUERY, 10'd0,    32'd0,         1'b0, 10'd0},
      '{CMD_QUERY, 10'd512,  COORD_MAX,     1'b0, 10'd0}
   };

   logic [COUNT_W-1:0] count_sweep [N_SWEEP] = '{
      11'd0, 11'd1, 11'd3, 11'd1024, 11'd2047, 11'd1025, 11'd2
   };

   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         csr_wr_en       = 1'b0;
   logic [COUNT_W-1:0]           csr_wr_data     = '0;
   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   logic                         req_cmd         = CMD_WRITE;
   logic [ENTRY_INDEX_W-1:0]     req_entry_index = '0;
   logic signed [COORD_IN_W-1:0] req_coordinate  = '0;
   logic                         rsp_valid;
   logic                         rsp_stall       = 1'b0;
   logic [NODE_INDEX_W-1:0]      rsp_node_index;

   // shadow of the block: table contents, node count, answers in flight
   logic [COORD_IN_W-1:0]   node_coord [NODE_DEPTH];
   bit                      entry_written [NODE_DEPTH];
   logic [COUNT_W-1:0]      node_count_cfg = COUNT_RESET;
   logic [NODE_INDEX_W-1:0] pending_nodes [$];

   int  mismatch_count  = 0;
   int  words_sent      = 0;
   int  queries_sent    = 0;
   int  results_checked = 0;
   int  settings_done   = 0;
   int  quiet_cycles    = 0;
   int  burst_left      = 0;
   bit  valid_up        = 1'b0;
   int  stall_mode      = 0;
   int  stall_run       = 0;

   nearest_grid_node_search i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_coordinate  (req_coordinate),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_node_index  (rsp_node_index)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int active_nodes();
      if (node_count_cfg < 2) return 2;
      if (node_count_cfg > NODE_DEPTH) return NODE_DEPTH;
      return int'(node_count_cfg);
   endfunction

   function automatic logic [31:0] node_key(int k);
      return node_coord[k] ^ KEY_OFFSET;
   endfunction

   // bounds first, then lower-bound bisection on exact midpoints
   function automatic logic [NODE_INDEX_W-1:0] nearest_node(logic [COORD_IN_W-1:0] coord);
      logic [31:0] q;
      logic [32:0] twice_q;
      logic [32:0] pair_sum;
      int          n;
      int          lo;
      int          hi;
      int          mid;
      n = active_nodes();
      q = coord ^ KEY_OFFSET;
      if (q < node_key(0)) return '0;
      if (q > node_key(n - 1)) return NODE_INDEX_W'(n - 1);
      lo = 0;
      hi = n - 1;
      twice_q = {q, 1'b0};
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         pair_sum = {1'b0, node_key(mid)} + {1'b0, node_key(mid + 1)};
         if (twice_q >= pair_sum) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      return NODE_INDEX_W'(lo);
   endfunction

   function automatic bit table_ready(int n);
      for (int i = 0; i < n; i++) begin
         if (!entry_written[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // aim most queries at nodes, midpoints and the two bounds
   function automatic logic [COORD_IN_W-1:0] pick_query(int n);
      int          k;
      logic [32:0] pair_sum;
      logic [31:0] offset;
      k = $urandom_range(0, n - 2);
      offset = 32'($signed($urandom_range(0, 2)) - 1);
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2, 3: return node_coord[k + $urandom_range(0, 1)] + offset;
         4, 5: begin
            pair_sum = {node_coord[k][31], node_coord[k]} + {node_coord[k+1][31], node_coord[k+1]};
            return pair_sum[32:1] + offset;
         end
         6: return node_coord[0] - 32'($urandom_range(1, 1000));
         7: return node_coord[n-1] + 32'($urandom_range(1, 1000));
         8: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         default: return node_coord[k] + 32'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic drop_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(80, 200) : $urandom_range(0, 20);
      end
   endtask

   task automatic send_word(input logic cmd, input logic [ENTRY_INDEX_W-1:0] entry,
                            input logic [COORD_IN_W-1:0] coord, input logic typed,
                            input logic [NODE_INDEX_W-1:0] node);
      req_valid       <= 1'b1;
      valid_up = 1'b1;
      req_cmd         <= cmd;
      req_entry_index <= entry;
      req_coordinate  <= coord;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_WRITE) begin
         node_coord[entry]    = coord;
         entry_written[entry] = 1'b1;
      end else begin
         pending_nodes.push_back(typed ? node : nearest_node(coord));
         queries_sent++;
      end
      words_sent++;
      pace();
   endtask

   // change the count only with the block drained and quiet
   task automatic set_node_count(input logic [COUNT_W-1:0] value);
      drop_valid();
      while (pending_nodes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_count_cfg = value;
      settings_done++;
   endtask

   task automatic load_table(int n);
      int vals [$];
      int base;
      int mode;
      mode = $urandom_range(0, 9);
      base = $urandom;
      for (int i = 0; i < n; i++) begin
         if (mode < 4) vals.push_back($urandom);
         else vals.push_back(base + $urandom_range(0, 3 * n));
      end
      if (mode < 8) vals.sort();
      if (mode == 9) begin
         vals.sort();
         vals.reverse();
      end
      for (int i = 0; i < n; i++) begin
         send_word(CMD_WRITE, ENTRY_INDEX_W'(i), vals[i], 1'b0, '0);
      end
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] value);
      int n;
      int n_queries;
      set_node_count(value);
      n = active_nodes();
      if (!table_ready(n) || (n <= 64 && $urandom_range(0, 4) != 0)) load_table(n);
      n_queries = $urandom_range(15, 50);
      for (int i = 0; i < n_queries; i++) begin
         // stray writes anywhere in the table, ignored index bits on queries
         if ($urandom_range(0, 9) == 0) begin
            send_word(CMD_WRITE, ENTRY_INDEX_W'($urandom), $urandom, 1'b0, '0);
         end else begin
            send_word(CMD_QUERY, ENTRY_INDEX_W'($urandom), pick_query(n), 1'b0, '0);
         end
      end
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 19))
         0: return COUNT_W'($urandom);
         1, 2: return COUNT_W'($urandom_range(65, NODE_DEPTH));
         3, 4, 5, 6, 7: return COUNT_W'($urandom_range(17, 64));
         default: return COUNT_W'($urandom_range(2, 16));
      endcase
   endfunction

   // receiver stall pattern: runs of free flow, light, heavy and bursty stall
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(10, 200);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1) == 0;
         2: rsp_stall <= $urandom_range(0, 3) != 0;
         default: rsp_stall <= stall_run[3];
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_nodes.size() == 0) begin
               $display("%0t: unexpected result word, node_index %0d", $time, rsp_node_index);
               mismatch_count++;
            end else begin
               if (rsp_node_index !== pending_nodes[0]) begin
                  $display("%0t: node_index mismatch, expected %0d, actual %0d",
                           $time, pending_nodes[0], rsp_node_index);
                  mismatch_count++;
               end
               void'(pending_nodes.pop_front());
               results_checked++;
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_nodes.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].cmd, directed_rows[i].entry, directed_rows[i].coord,
                   directed_rows[i].typed, directed_rows[i].node);
      end
      foreach (count_sweep[i]) run_phase(count_sweep[i]);
      while (words_sent < TARGET_WORDS) run_phase(pick_count());
      drop_valid();
      while (pending_nodes.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("%0d words sent (%0d queries), %0d results checked", words_sent, queries_sent,
               results_checked);
      $display("%0d node-count settings, %0d mismatches", settings_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
design/ngns_pkg.sv
design/ngns_ctrl.sv
design/ngns_datapath.sv
design/nearest_grid_node_search.sv
design/ngns_checker.sv
dv/testbench.sv
